@@ rtl/tkst_pkg.sv @@
// Shared types and constants for the top-k score table.
package tkst_pkg;

	localparam int TABLE_SIZE_DEF = 64;
	localparam int MAX_RESULTS    = 64;
	localparam int SCORE_W        = 32;
	localparam int RANK_W         = 6;
	localparam int COUNT_W        = 7;
	localparam int OP_W           = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_RD,
		ST_INS_CMP,
		ST_RD_REQ,
		ST_RD_OUT,
		ST_STATUS
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic clear;
		logic ins_read;
		logic ins_shift;
		logic ins_place;
		logic rd_read;
		logic rd_emit;
		logic st_emit;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            n_zero;
		logic            i_zero;
		logic            above;
		logic            last_entry;
		logic            out_free;
	} dp_stat_t;

endpackage

@@ rtl/tkst_ctrl.sv @@
// Sequencer for insert, clear and read transactions of the score table.
module tkst_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tkst_pkg::dp_stat_t   st,
	output tkst_pkg::ctrl_cmd_t  cmd
);
	import tkst_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (st.op)
					OP_INSERT: state_nxt = ST_INS_RD;
					OP_READ:   state_nxt = st.n_zero ? ST_STATUS : ST_RD_REQ;
					default:   state_nxt = ST_STATUS;
				endcase
			end
			ST_INS_RD: begin
				state_nxt = st.i_zero ? ST_STATUS : ST_INS_CMP;
			end
			ST_INS_CMP: begin
				state_nxt = st.above ? ST_INS_RD : ST_STATUS;
			end
			ST_RD_REQ: begin
				state_nxt = ST_RD_OUT;
			end
			ST_RD_OUT: begin
				if (st.out_free) state_nxt = st.last_entry ? ST_IDLE : ST_RD_REQ;
			end
			ST_STATUS: begin
				if (st.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			ST_DISPATCH: begin
				cmd.clear = (st.op == OP_CLEAR);
			end
			ST_INS_RD: begin
				cmd.ins_place = st.i_zero;
				cmd.ins_read  = !st.i_zero;
			end
			ST_INS_CMP: begin
				cmd.ins_shift = st.above;
				cmd.ins_place = !st.above;
			end
			ST_RD_REQ: begin
				cmd.rd_read = 1'b1;
			end
			ST_RD_OUT: begin
				cmd.rd_emit = st.out_free;
			end
			ST_STATUS: begin
				cmd.st_emit = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/tkst_dp.sv @@
// Datapath: sorted score memory, count, walk indexes and output register.
module tkst_dp #(
	parameter int TABLE_SIZE = tkst_pkg::TABLE_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tkst_pkg::ctrl_cmd_t          cmd,
	output tkst_pkg::dp_stat_t           st,
	input  logic [tkst_pkg::OP_W-1:0]    in_op,
	input  logic [tkst_pkg::SCORE_W-1:0] in_score,
	input  logic [tkst_pkg::COUNT_W-1:0] in_read_count,
	output logic                         out_tvalid,
	input  logic                         out_tready,
	output logic [tkst_pkg::SCORE_W-1:0] out_score,
	output logic [tkst_pkg::RANK_W-1:0]  out_rank,
	output logic                         out_valid,
	output logic                         out_last,
	output logic [tkst_pkg::COUNT_W-1:0] out_count
);
	import tkst_pkg::*;

	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

	logic [SCORE_W-1:0] mem [TABLE_SIZE];
	logic [SCORE_W-1:0] rd_data_q;

	logic [OP_W-1:0]    op_q;
	logic [SCORE_W-1:0] score_q;
	logic [CW-1:0]      held_q;
	logic [CW-1:0]      i_q;
	logic [COUNT_W-1:0] k_q;
	logic [COUNT_W-1:0] n_q;
	logic               tvalid_q;

	logic [CW-1:0]      i_m1;
	logic               i_in_table;
	logic               held_full;
	logic               mem_we;
	logic               mem_re;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic [SCORE_W-1:0] wdata;
	logic [XW-1:0]      held_x;
	logic [XW-1:0]      want_x;
	logic [XW-1:0]      n_x;
	logic               out_free;

	assign i_m1       = i_q - CW'(1);
	assign i_in_table = (i_q != CW'(TABLE_SIZE));
	assign held_full  = (held_q == CW'(TABLE_SIZE));

	// read length: min(read_count, held entries, result cap)
	assign held_x = XW'(held_q);
	assign want_x = XW'(in_read_count);
	always_comb begin
		n_x = want_x;
		if (n_x > held_x) n_x = held_x;
		if (n_x > XW'(MAX_RESULTS)) n_x = XW'(MAX_RESULTS);
	end

	// entries move one slot down while the new score is above them
	assign mem_we = (cmd.ins_shift || cmd.ins_place) && i_in_table;
	assign waddr  = i_q[AW-1:0];
	assign wdata  = cmd.ins_shift ? rd_data_q : score_q;
	assign mem_re = cmd.ins_read || cmd.rd_read;
	assign raddr  = cmd.rd_read ? AW'(k_q) : i_m1[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_re) rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= in_op;
			score_q <= in_score;
			i_q     <= held_q;
			k_q     <= '0;
			n_q     <= COUNT_W'(n_x);
		end else begin
			if (cmd.ins_shift) i_q <= i_m1;
			if (cmd.rd_emit)   k_q <= k_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.clear) begin
			held_q <= '0;
		end else if (cmd.ins_place && !held_full) begin
			held_q <= held_q + CW'(1);
		end
	end

	// output register
	assign out_free = !tvalid_q || out_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (cmd.rd_emit || cmd.st_emit) begin
			tvalid_q <= 1'b1;
		end else if (out_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_emit) begin
			out_score <= rd_data_q;
			out_rank  <= k_q[RANK_W-1:0];
			out_valid <= 1'b1;
			out_last  <= st.last_entry;
			out_count <= COUNT_W'(held_q);
		end else if (cmd.st_emit) begin
			out_score <= '0;
			out_rank  <= '0;
			out_valid <= 1'b0;
			out_last  <= 1'b1;
			out_count <= COUNT_W'(held_q);
		end
	end

	assign out_tvalid = tvalid_q;

	assign st.op         = op_q;
	assign st.n_zero     = (n_q == '0);
	assign st.i_zero     = (i_q == '0);
	assign st.above      = $signed(score_q) > $signed(rd_data_q);
	assign st.last_entry = ((k_q + COUNT_W'(1)) == n_q);
	assign st.out_free   = out_free;

endmodule

@@ rtl/top_k_score_table.sv @@
// Top level of the top-k score table: sequencer plus sorted-table datapath.
//
// Usage: one input transaction on the s_ side carries an operation in s_tuser
// (insert, clear, read) with its score and read count in s_tdata. Results
// leave on the m_ side; m_tlast marks the final result of each input
// transaction and m_tuser flags a result that carries a table entry.
// Insert and clear (and the unused op code) give one status result; a read
// gives one result per entry in rank order, or one status result when it
// finds nothing.
// Timing: s_tready is high only while the sequencer is idle, so one input
// transaction is worked on at a time. Insert walks the table from its tail;
// each entry that moves takes one memory read, then one compare and write
// on the single-port score memory; the walk ends when the new score is
// placed, and a status result follows. A read does a memory read, then
// an output load, for each entry that it returns.
// Reset: arst_n empties the table; the memory itself is not cleared, since
// only entries below the count are ever read. Stalls: results sit in one
// output register; while m_tready is low the sequencer holds before its
// next output load and no work is lost.
module top_k_score_table #(
	parameter int TABLE_SIZE = tkst_pkg::TABLE_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // score [31:0], read_count [38:32], zero pad
	input  logic [1:0]  s_tuser,   // op [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_score [31:0], out_rank [37:32],
	                               // entry_count [44:38], zero pad
	output logic [0:0]  m_tuser,   // out_valid [0]
	output logic        m_tlast    // out_last
);
	import tkst_pkg::*;

	ctrl_cmd_t          cmd;
	dp_stat_t           st;
	logic [SCORE_W-1:0] out_score;
	logic [RANK_W-1:0]  out_rank;
	logic               out_valid;
	logic [COUNT_W-1:0] out_count;

	tkst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tkst_dp #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.in_op         (s_tuser),
		.in_score      (s_tdata[31:0]),
		.in_read_count (s_tdata[38:32]),
		.out_tvalid    (m_tvalid),
		.out_tready    (m_tready),
		.out_score     (out_score),
		.out_rank      (out_rank),
		.out_valid     (out_valid),
		.out_last      (m_tlast),
		.out_count     (out_count)
	);

	assign m_tdata    = {3'b000, out_count, out_rank, out_score};
	assign m_tuser[0] = out_valid;

endmodule

@@ sim/top_k_score_table_tb.sv @@
// Self-checking testbench for top_k_score_table: directed script, random traffic, scoreboard.
module top_k_score_table_tb;
	import tkst_pkg::*;

	localparam int         TBL          = TABLE_SIZE_DEF;
	localparam logic [1:0] OP_NOP       = 2'd3;     // unused op code, behaves as a no-op
	localparam int         RANDOM_ITEMS = 237;
	localparam int         LIMIT_CYCLES = 1_000_000;
	localparam int         TAIL_CYCLES  = 40;

	// one result transaction as seen on the m_ side
	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [RANK_W-1:0]         rank;
		logic [COUNT_W-1:0]        count;
		logic                      valid;
		logic                      last;
	} result_t;

	// one row of the directed script; typed rows carry their status count
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [SCORE_W-1:0] score;
		logic [COUNT_W-1:0] want;
		logic               typed;
		logic [COUNT_W-1:0] count;
	} step_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;   // score [31:0], read_count [38:32], zero pad
	logic [1:0]  s_tuser  = '0;   // op [1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // out_score [31:0], out_rank [37:32], entry_count [44:38]
	logic [0:0]  m_tuser;         // out_valid [0]
	logic        m_tlast;

	// shadow copy of the ranked table
	logic signed [SCORE_W-1:0] ranked [TBL];
	int                        held;

	result_t fresh_q[$];          // results of the most recent operation
	result_t pending_results[$];  // results still owed by the block

	int send_idle_pct = 25;
	int recv_idle_pct = 68;
	int items_sent    = 0;
	int results_seen  = 0;
	int drops_on_full = 0;
	int peak_held     = 0;
	int err_count     = 0;
	int cycle_count   = 0;

	step_t script [0:23] = '{
		'{OP_READ,   32'h0000_0000,   7'd5, 1'b1, 7'd0},  // read of an empty table
		'{OP_INSERT, 32'h0000_0000,   7'd0, 1'b1, 7'd1},
		'{OP_INSERT, 32'h7fff_ffff,   7'd0, 1'b1, 7'd2},
		'{OP_INSERT, 32'h8000_0000,   7'd0, 1'b1, 7'd3},
		'{OP_INSERT, 32'hffff_ffff,   7'd0, 1'b1, 7'd4},
		'{OP_INSERT, 32'h0000_0000,   7'd0, 1'b1, 7'd5},  // tie with an existing entry
		'{OP_INSERT, 32'h0000_0001,   7'd0, 1'b1, 7'd6},
		'{OP_READ,   32'h0000_0000,   7'd0, 1'b1, 7'd6},  // zero count: status only
		'{OP_READ,   32'h0000_0000,   7'd3, 1'b0, 7'd0},
		'{OP_READ,   32'h0000_0000, 7'd127, 1'b0, 7'd0},  // count beyond held entries
		'{OP_NOP,    32'h0000_0000,   7'd0, 1'b1, 7'd6},
		'{OP_INSERT, 32'h8000_0000,   7'd0, 1'b1, 7'd7},
		'{OP_INSERT, 32'h7fff_ffff,   7'd0, 1'b1, 7'd8},
		'{OP_READ,   32'h0000_0000,  7'd64, 1'b0, 7'd0},
		'{OP_CLEAR,  32'h0000_0000,   7'd0, 1'b1, 7'd0},
		'{OP_READ,   32'h0000_0000,  7'd64, 1'b1, 7'd0},  // read after clear
		'{OP_CLEAR,  32'h0000_0000,   7'd0, 1'b1, 7'd0},  // clear of an empty table
		'{OP_INSERT, 32'h5555_5555,   7'd0, 1'b1, 7'd1},
		'{OP_INSERT, 32'haaaa_aaaa,   7'd0, 1'b1, 7'd2},
		'{OP_READ,   32'h0000_0000,   7'd1, 1'b0, 7'd0},
		'{OP_READ,   32'h0000_0000,   7'd2, 1'b0, 7'd0},
		'{OP_NOP,    32'hffff_ffff, 7'd127, 1'b1, 7'd2},
		'{OP_INSERT, 32'hffff_ffff, 7'd127, 1'b1, 7'd3},  // insert ignores read_count
		'{OP_READ,   32'hffff_ffff, 7'd127, 1'b0, 7'd0}
	};

	top_k_score_table #(
		.TABLE_SIZE(TBL)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Applies one operation to the shadow table and leaves its results in fresh_q.
	function automatic void apply_to_table(input logic [OP_W-1:0] op,
	                                       input logic signed [SCORE_W-1:0] sc,
	                                       input logic [COUNT_W-1:0] want);
		int      pos;
		int      n;
		result_t res;
		fresh_q.delete();
		res      = '0;
		res.last = 1'b1;
		case (op)
			OP_INSERT: begin
				pos = 0;
				// ties go behind the entries equal to the new score
				while (pos < held && !(sc > ranked[pos]))
					pos++;
				if (pos >= TBL) begin
					drops_on_full++;
				end else begin
					if (held < TBL)
						held++;
					for (int i = held - 1; i > pos; i--)
						ranked[i] = ranked[i - 1];
					ranked[pos] = sc;
				end
			end
			OP_CLEAR: begin
				held = 0;
			end
			OP_READ: begin
				n = int'(want);
				if (n > held)
					n = held;
				if (n > MAX_RESULTS)
					n = MAX_RESULTS;
				for (int k = 0; k < n; k++) begin
					res.score = ranked[k];
					res.rank  = RANK_W'(k);
					res.count = COUNT_W'(held);
					res.valid = 1'b1;
					res.last  = (k == n - 1);
					fresh_q = {fresh_q, res};
				end
			end
			default: ;
		endcase
		// status result for everything that streams no entries
		if (fresh_q.size() == 0) begin
			res       = '0;
			res.last  = 1'b1;
			res.count = COUNT_W'(held);
			fresh_q = {fresh_q, res};
		end
		if (held > peak_held)
			peak_held = held;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] exp_v);
		err_count++;
		$display("mismatch on %s: got %h expected %h (result %0d)",
		         what, got, exp_v, results_seen);
	endtask

	// Presents one transaction, waits for acceptance and records what it owes.
	task automatic send_op(input logic [OP_W-1:0] op, input logic [SCORE_W-1:0] sc,
	                       input logic [COUNT_W-1:0] want, input logic typed,
	                       input logic [COUNT_W-1:0] typed_count);
		result_t st;
		do
			@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, want, sc};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_to_table(op, sc, want);
		if (typed) begin
			st       = '0;
			st.last  = 1'b1;
			st.count = typed_count;
			pending_results = {pending_results, st};
		end else begin
			pending_results = {pending_results, fresh_q};
		end
		items_sent++;
		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tuser  <= 2'($urandom);
		s_tdata  <= {8'($urandom), 32'($urandom)};
	endtask

	task automatic wait_all_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// result scoreboard
	always @(posedge clk) begin
		result_t w;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
			end else begin
				w = pending_results.pop_front();
				if (m_tdata[31:0] !== w.score)
					report_mismatch("out_score", m_tdata[31:0], w.score);
				if (m_tdata[37:32] !== w.rank)
					report_mismatch("out_rank", 32'(m_tdata[37:32]), 32'(w.rank));
				if (m_tdata[44:38] !== w.count)
					report_mismatch("entry_count", 32'(m_tdata[44:38]), 32'(w.count));
				if (m_tuser[0] !== w.valid)
					report_mismatch("out_valid", 32'(m_tuser[0]), 32'(w.valid));
				if (m_tlast !== w.last)
					report_mismatch("out_last", 32'(m_tlast), 32'(w.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results owed",
			         cycle_count, pending_results.size());
			$display("[top_k_score_table] ERROR");
			$finish;
		end
	end

	initial begin
		int                 r;
		logic [OP_W-1:0]    op;
		logic [SCORE_W-1:0] sc;
		logic [COUNT_W-1:0] want;
		held = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_op(script[i].op, script[i].score, script[i].want,
			        script[i].typed, script[i].count);
		wait_all_results();

		// three idling modes; the sender holds off between them until the block drains
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 25; recv_idle_pct = 68; end
				1: begin send_idle_pct = 68; recv_idle_pct = 25; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			repeat (RANDOM_ITEMS / 3) begin
				// insert-heavy so the table fills; clear only once it is full
				r = $urandom_range(0, 99);
				if (r < 60)
					op = OP_INSERT;
				else if (r < 85)
					op = OP_READ;
				else if (r < 90)
					op = OP_NOP;
				else if (held == TBL && $urandom_range(0, 3) == 0)
					op = OP_CLEAR;
				else
					op = OP_INSERT;
				case ($urandom_range(0, 7))
					0, 1: sc = 32'($urandom_range(0, 16)) - 32'd8;  // many ties
					2: begin
						case ($urandom_range(0, 3))
							0: sc = 32'h7fff_ffff;
							1: sc = 32'h8000_0000;
							2: sc = 32'h0000_0000;
							default: sc = 32'hffff_ffff;
						endcase
					end
					default: sc = $urandom;
				endcase
				case ($urandom_range(0, 3))
					0: want = 7'($urandom_range(0, 127));
					1: want = COUNT_W'(held);
					default: want = 7'($urandom_range(0, 8));
				endcase
				send_op(op, sc, want, 1'b0, '0);
			end
			wait_all_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d transactions (%0d directed) and %0d results in %0d cycles",
		         items_sent, $size(script), results_seen, cycle_count);
		$display("table peaked at %0d of %0d entries, %0d scores fell off a full table",
		         peak_held, TBL, drops_on_full);
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("[top_k_score_table] OK");
		end else begin
			$display("[top_k_score_table] ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/tkst_pkg.sv
rtl/tkst_ctrl.sv
rtl/tkst_dp.sv
rtl/top_k_score_table.sv
sim/top_k_score_table_tb.sv
